/* hw/rtl/wtr_pkg.sv */
// Shared types, widths and constants for the wavelength to RGB pipeline.
`timescale 1ns / 1ps
`default_nettype none

package wtr_pkg;

    localparam int GAMMA_INDEX_BITS_DEF   = 10;
    localparam int WAVE_FRACTION_BITS_DEF = 4;

    // Stream widths.
    localparam int IN_W        = 14;
    localparam int IN_TDATA_W  = 16;
    localparam int LEVEL_W     = 8;
    localparam int OUT_TDATA_W = 3 * LEVEL_W;

    // Pipeline depth before the output skid buffer.
    localparam int NSTAGE = 5;

    // Internal arithmetic widths.
    localparam int CMP_W       = 18;  // holds 781 nm at the finest input resolution
    localparam int DIST_W      = 15;  // distance into one segment
    localparam int NUM_W       = 23;  // dividend fed to the reciprocal multiplier
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 30;
    localparam int Q_FRAC      = 16;
    localparam int WT_W        = Q_FRAC + 1;  // Q1.16, up to and including 1.0
    localparam int FAC_PROD_W  = Q_FRAC + DIST_W;

    localparam logic [WT_W-1:0]   ONE_Q16    = WT_W'(65536);
    localparam logic [WT_W-1:0]   POINT3_Q16 = WT_W'(19661);
    localparam logic [Q_FRAC-1:0] POINT7_Q16 = Q_FRAC'(45875);

    // Reciprocals rounded up. With a dividend below 2^23 and a divisor below
    // 128 the scaled product floors to the exact quotient.
    localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20);
    localparam logic [RECIP_W-1:0] RECIP_40 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd39) / 64'd40);
    localparam logic [RECIP_W-1:0] RECIP_50 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd49) / 64'd50);
    localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd59) / 64'd60);
    localparam logic [RECIP_W-1:0] RECIP_65 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd64) / 64'd65);
    localparam logic [RECIP_W-1:0] RECIP_70 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd69) / 64'd70);
    localparam logic [RECIP_W-1:0] RECIP_80 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd79) / 64'd80);

    typedef enum logic [2:0] {
        DIV_20, DIV_40, DIV_50, DIV_60, DIV_65, DIV_70, DIV_80
    } div_t;

    typedef enum logic [1:0] {
        CH_NONE, CH_RED, CH_GREEN, CH_BLUE
    } chan_t;

    typedef enum logic [1:0] {
        FAC_ZERO, FAC_ONE, FAC_UP, FAC_DOWN
    } fac_mode_t;

    localparam logic [2:0] MASK_RED   = 3'b001;
    localparam logic [2:0] MASK_GREEN = 3'b010;
    localparam logic [2:0] MASK_BLUE  = 3'b100;
    localparam int BIT_RED   = 0;
    localparam int BIT_GREEN = 1;
    localparam int BIT_BLUE  = 2;

    typedef struct packed {
        chan_t     ramp_ch;
        logic [2:0] one_mask;
        fac_mode_t fac_mode;
        logic      fac_neg;
    } ctl_t;

    typedef struct packed {
        ctl_t              ctl;
        logic [NUM_W-1:0]  ramp_num;
        div_t              ramp_div;
        logic [NUM_W-1:0]  fac_num;
        div_t              fac_div;
    } cls_t;

    function automatic logic [RECIP_W-1:0] recip(input div_t sel);
        logic [RECIP_W-1:0] r;
        unique case (sel)
            DIV_20:  r = RECIP_20;
            DIV_40:  r = RECIP_40;
            DIV_50:  r = RECIP_50;
            DIV_60:  r = RECIP_60;
            DIV_65:  r = RECIP_65;
            DIV_70:  r = RECIP_70;
            DIV_80:  r = RECIP_80;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/wavelength_to_rgb.sv */
// Wavelength to RGB LED levels: five-stage pipeline with an output skid buffer.
//
// A wavelength word enters on the s_ channel (tdata bits [13:0], in 1/16 nm by
// default) and the three gamma-corrected levels leave on the m_ channel, packed
// red, blue, green from the low byte up. Each input word gives exactly one
// result word, in order.
// Stages: segment and fall-off decode, reciprocal divide, weight and factor
// select, weight times factor, gamma ROM read; then the output register.
// A word taken on the s_ channel passes through the stage registers and then the
// output register before it shows on m_tvalid; a stall at m_tready holds it back.
// Throughput is one word per clock cycle while m_tready stays high; the multipliers
// and the ROM lookup are each alone in a stage, and each stage then takes a new word.
// When m_tready is low the output register holds its word, the skid entry takes
// one more, and the stages fill any empty slots; s_tready drops only once all
// seven slots hold words, and nothing is dropped or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline and the output.
`timescale 1ns / 1ps
`default_nettype none

module wavelength_to_rgb
    import wtr_pkg::*;
#(
    parameter int GAMMA_INDEX_BITS   = GAMMA_INDEX_BITS_DEF,
    parameter int WAVE_FRACTION_BITS = WAVE_FRACTION_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [13:0] wavelength_sixteenths
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata    // [7:0] red, [15:8] blue, [23:16] green
);

    logic [NSTAGE-1:0] stage_valid_reg;
    logic [NSTAGE-1:0] stage_valid_next;
    logic [NSTAGE-1:0] stage_en;
    logic              skid_ready;

    cls_t            cls;
    logic [WT_W-1:0] ramp_q;
    logic [WT_W-1:0] fac_q;
    ctl_t            ctl_s2_reg;

    logic [WT_W-1:0] wt_red_reg;
    logic [WT_W-1:0] wt_red_next;
    logic [WT_W-1:0] wt_green_reg;
    logic [WT_W-1:0] wt_green_next;
    logic [WT_W-1:0] wt_blue_reg;
    logic [WT_W-1:0] wt_blue_next;
    logic [WT_W-1:0] fac_reg;
    logic [WT_W-1:0] fac_next;

    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    // A stage loads when it is empty or its word moves on in the same cycle.
    always_comb begin
        stage_en[NSTAGE-1] = !stage_valid_reg[NSTAGE-1] || skid_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !stage_valid_reg[k] || stage_en[k+1];
        end
        stage_valid_next[0] = stage_en[0] ? s_tvalid : stage_valid_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            stage_valid_next[k] = stage_en[k] ? stage_valid_reg[k-1] : stage_valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    assign s_tready = stage_en[0];

    wtr_classify #(
        .WAVE_FRACTION_BITS(WAVE_FRACTION_BITS)
    ) u_classify (
        .aclk (aclk),
        .en   (stage_en[0]),
        .wave (s_tdata[IN_W-1:0]),
        .cls  (cls)
    );

    wtr_recip_div u_ramp_div (
        .aclk    (aclk),
        .en      (stage_en[1]),
        .num     (cls.ramp_num),
        .div_sel (cls.ramp_div),
        .quo     (ramp_q)
    );

    wtr_recip_div u_fac_div (
        .aclk    (aclk),
        .en      (stage_en[1]),
        .num     (cls.fac_num),
        .div_sel (cls.fac_div),
        .quo     (fac_q)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            ctl_s2_reg <= cls.ctl;
        end
    end

    always_comb begin
        unique case (ctl_s2_reg.fac_mode)
            FAC_ZERO: fac_next = '0;
            FAC_ONE:  fac_next = ONE_Q16;
            FAC_UP:   fac_next = POINT3_Q16 + fac_q;
            FAC_DOWN: fac_next = ctl_s2_reg.fac_neg ? (POINT3_Q16 - fac_q)
                                                    : (POINT3_Q16 + fac_q);
        endcase

        wt_red_next   = ctl_s2_reg.one_mask[BIT_RED] ? ONE_Q16 :
                        (ctl_s2_reg.ramp_ch == CH_RED) ? ramp_q : '0;
        wt_green_next = ctl_s2_reg.one_mask[BIT_GREEN] ? ONE_Q16 :
                        (ctl_s2_reg.ramp_ch == CH_GREEN) ? ramp_q : '0;
        wt_blue_next  = ctl_s2_reg.one_mask[BIT_BLUE] ? ONE_Q16 :
                        (ctl_s2_reg.ramp_ch == CH_BLUE) ? ramp_q : '0;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            wt_red_reg   <= wt_red_next;
            wt_green_reg <= wt_green_next;
            wt_blue_reg  <= wt_blue_next;
            fac_reg      <= fac_next;
        end
    end

    wtr_gamma_lane #(
        .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
    ) u_lane_red (
        .aclk   (aclk),
        .en_mul (stage_en[3]),
        .en_rom (stage_en[4]),
        .weight (wt_red_reg),
        .factor (fac_reg),
        .level  (red_level)
    );

    wtr_gamma_lane #(
        .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
    ) u_lane_green (
        .aclk   (aclk),
        .en_mul (stage_en[3]),
        .en_rom (stage_en[4]),
        .weight (wt_green_reg),
        .factor (fac_reg),
        .level  (green_level)
    );

    wtr_gamma_lane #(
        .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
    ) u_lane_blue (
        .aclk   (aclk),
        .en_mul (stage_en[3]),
        .en_rom (stage_en[4]),
        .weight (wt_blue_reg),
        .factor (fac_reg),
        .level  (blue_level)
    );

    wtr_out_skid u_out_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stage_valid_reg[NSTAGE-1]),
        .in_ready (skid_ready),
        .in_data  ({green_level, blue_level, red_level}),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/wtr_classify.sv */
// First stage: finds the color segment and fall-off region of a wavelength.
`timescale 1ns / 1ps
`default_nettype none

module wtr_classify
    import wtr_pkg::*;
#(
    parameter int WAVE_FRACTION_BITS = WAVE_FRACTION_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [IN_W-1:0] wave,
    output cls_t                 cls
);

    localparam logic [CMP_W-1:0] W380 = CMP_W'(380) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W420 = CMP_W'(420) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W440 = CMP_W'(440) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W490 = CMP_W'(490) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W510 = CMP_W'(510) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W580 = CMP_W'(580) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W645 = CMP_W'(645) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W701 = CMP_W'(701) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W780 = CMP_W'(780) << WAVE_FRACTION_BITS;
    localparam logic [CMP_W-1:0] W781 = CMP_W'(781) << WAVE_FRACTION_BITS;

    cls_t                  cls_reg;
    cls_t                  cls_next;
    logic [CMP_W-1:0]      w;
    logic [DIST_W-1:0]     ramp_dist;
    logic [DIST_W-1:0]     fac_dist;
    logic [FAC_PROD_W-1:0] fac_prod;

    always_comb begin
        w         = CMP_W'(wave);
        ramp_dist = '0;
        fac_dist  = '0;
        cls_next.ctl.ramp_ch  = CH_NONE;
        cls_next.ctl.one_mask = '0;
        cls_next.ctl.fac_mode = FAC_ZERO;
        cls_next.ctl.fac_neg  = 1'b0;
        cls_next.ramp_div     = DIV_20;
        cls_next.fac_div      = DIV_40;

        if (w >= W380 && w < W440) begin
            cls_next.ctl.ramp_ch  = CH_RED;
            cls_next.ctl.one_mask = MASK_BLUE;
            ramp_dist             = DIST_W'(W440 - w);
            cls_next.ramp_div     = DIV_60;
        end else if (w >= W440 && w < W490) begin
            cls_next.ctl.ramp_ch  = CH_GREEN;
            cls_next.ctl.one_mask = MASK_BLUE;
            ramp_dist             = DIST_W'(w - W440);
            cls_next.ramp_div     = DIV_50;
        end else if (w >= W490 && w < W510) begin
            cls_next.ctl.ramp_ch  = CH_BLUE;
            cls_next.ctl.one_mask = MASK_GREEN;
            ramp_dist             = DIST_W'(W510 - w);
            cls_next.ramp_div     = DIV_20;
        end else if (w >= W510 && w < W580) begin
            cls_next.ctl.ramp_ch  = CH_RED;
            cls_next.ctl.one_mask = MASK_GREEN;
            ramp_dist             = DIST_W'(w - W510);
            cls_next.ramp_div     = DIV_70;
        end else if (w >= W580 && w < W645) begin
            cls_next.ctl.ramp_ch  = CH_GREEN;
            cls_next.ctl.one_mask = MASK_RED;
            ramp_dist             = DIST_W'(W645 - w);
            cls_next.ramp_div     = DIV_65;
        end else if (w >= W645 && w < W781) begin
            cls_next.ctl.one_mask = MASK_RED;
        end

        // Distance in Q.16 before the divide by the segment length.
        cls_next.ramp_num = NUM_W'({ramp_dist, {Q_FRAC{1'b0}}} >> WAVE_FRACTION_BITS);

        if (w >= W380 && w < W420) begin
            cls_next.ctl.fac_mode = FAC_UP;
            fac_dist              = DIST_W'(w - W380);
            cls_next.fac_div      = DIV_40;
        end else if (w >= W420 && w < W701) begin
            cls_next.ctl.fac_mode = FAC_ONE;
        end else if (w >= W701 && w < W781) begin
            // Between 780 and 781 nm the fall-off factor drops slightly below 0.3.
            cls_next.ctl.fac_mode = FAC_DOWN;
            cls_next.ctl.fac_neg  = (w > W780);
            fac_dist              = (w > W780) ? DIST_W'(w - W780) : DIST_W'(W780 - w);
            cls_next.fac_div      = DIV_80;
        end

        fac_prod         = FAC_PROD_W'(POINT7_Q16) * FAC_PROD_W'(fac_dist);
        cls_next.fac_num = NUM_W'(fac_prod >> WAVE_FRACTION_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls_reg <= cls_next;
        end
    end

    assign cls = cls_reg;

endmodule

`default_nettype wire

/* hw/rtl/wtr_recip_div.sv */
// Registered divide by one of the segment or fall-off lengths, done as a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module wtr_recip_div
    import wtr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  div_t                  div_sel,
    output logic [WT_W-1:0]       quo
);

    logic [NUM_W+RECIP_W-1:0] prod;
    logic [WT_W-1:0]          quo_reg;

    assign prod = (NUM_W + RECIP_W)'(num) * (NUM_W + RECIP_W)'(recip(div_sel));

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= WT_W'(prod >> RECIP_SHIFT);
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

/* hw/rtl/wtr_gamma_lane.sv */
// One color lane: applies the fall-off factor and looks up the gamma ROM.
`timescale 1ns / 1ps
`default_nettype none

module wtr_gamma_lane
    import wtr_pkg::*;
#(
    parameter int GAMMA_INDEX_BITS = GAMMA_INDEX_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              en_mul,
    input  wire logic              en_rom,
    input  wire logic [WT_W-1:0]   weight,
    input  wire logic [WT_W-1:0]   factor,
    output logic      [LEVEL_W-1:0] level
);

    localparam int IDX_W    = GAMMA_INDEX_BITS + 1;
    localparam int ROM_SIZE = (1 << GAMMA_INDEX_BITS) + 1;
    localparam int PROD_W   = 2 * WT_W;
    localparam int CALC_W   = 96;

    // Largest y with (y/255)^5 <= (i/2^B)^4, worked out in exact integers.
    function automatic logic [LEVEL_W-1:0] gamma_entry(input int i);
        logic [CALC_W-1:0] n4;
        logic [CALC_W-1:0] full5;
        logic [CALC_W-1:0] i4;
        logic [CALC_W-1:0] t;
        logic [CALC_W-1:0] t5;
        logic [CALC_W-1:0] y;
        n4    = CALC_W'(1) << (4 * GAMMA_INDEX_BITS);
        full5 = CALC_W'(255) * CALC_W'(255) * CALC_W'(255) * CALC_W'(255) * CALC_W'(255);
        i4    = CALC_W'(i) * CALC_W'(i) * CALC_W'(i) * CALC_W'(i);
        y     = '0;
        for (int b = LEVEL_W - 1; b >= 0; b--) begin
            t  = y | (CALC_W'(1) << b);
            t5 = t * t * t * t * t;
            if (t5 * n4 <= full5 * i4) begin
                y = t;
            end
        end
        return LEVEL_W'(y);
    endfunction

    logic [LEVEL_W-1:0] gamma_rom [ROM_SIZE];

    // The table is constant; it is filled once at start-up.
    initial begin
        for (int i = 0; i < ROM_SIZE; i++) begin
            gamma_rom[i] = gamma_entry(i);
        end
    end

    logic [PROD_W-1:0]  prod;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEVEL_W-1:0] level_reg;

    assign prod = PROD_W'(weight) * PROD_W'(factor);

    // The product is Q2.32 with 1.0 at bit 2*Q_FRAC; that bit and the bits below it index the ROM.
    always_ff @(posedge aclk) begin
        if (en_mul) begin
            idx_reg <= prod[2*Q_FRAC -: IDX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_rom) begin
            level_reg <= gamma_rom[idx_reg];
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

/* hw/rtl/wtr_out_skid.sv */
// Output register with a skid entry so the pipeline ready is registered.
`timescale 1ns / 1ps
`default_nettype none

module wtr_out_skid
    import wtr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [OUT_TDATA_W-1:0] in_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [OUT_TDATA_W-1:0] skid_data_reg;
    logic [OUT_TDATA_W-1:0] skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/wtr_checker.sv */
// Port-level checks for wavelength_to_rgb and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module wtr_checker
    import wtr_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // Pipeline stages plus the output register and the skid entry.
    localparam int CAP   = NSTAGE + 2;
    localparam int CNT_W = $clog2(CAP + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (in_acc && !out_acc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // No result word without a word in flight.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> count_reg != '0)
        else $error("result word with nothing in flight");

    // Input backpressure only once every slot is occupied.
    a_full_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> count_reg == CNT_W'(CAP))
        else $error("input stalled while the pipeline has room");

    // No segment lights all three channels at once.
    a_two_colors: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == '0 || m_tdata[15:8] == '0 || m_tdata[23:16] == '0))
        else $error("all three color levels nonzero");

endmodule

bind wavelength_to_rgb wtr_checker u_wtr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
